>>> rtl/sstf_pkg.sv
`timescale 1ns / 1ps

package sstf_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_BITS = 48;
    localparam int FIELD_BITS  = 48;
    localparam int TAG_BITS    = 8;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W      = SECTOR_BITS + TAG_BITS;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NOTAG = 2'd3
    } t_status;

    // result of the shared compare unit for one slot
    typedef struct packed {
        logic [SECTOR_BITS-1:0] distance;
        logic                   closer;
        logic                   right;
        logic                   tag_hit;
    } t_cmp_res;

    // 48-bit port field to internal sector width
    function automatic logic [SECTOR_BITS-1:0] to_sector(input logic [FIELD_BITS-1:0] f);
        logic [SECTOR_BITS-1:0] s;
        for (int i = 0; i < SECTOR_BITS; i++) begin
            s[i] = (i < FIELD_BITS) ? f[i] : 1'b0;
        end
        return s;
    endfunction

    // internal sector width to 48-bit port field
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [SECTOR_BITS-1:0] s);
        logic [FIELD_BITS-1:0] f;
        for (int i = 0; i < FIELD_BITS; i++) begin
            f[i] = (i < SECTOR_BITS) ? s[i] : 1'b0;
        end
        return f;
    endfunction

endpackage

>>> rtl/sstf_ram.sv
`timescale 1ns / 1ps

module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/sstf_cmp_unit.sv
`timescale 1ns / 1ps

module sstf_cmp_unit
    import sstf_pkg::*;
(
    input  logic [SECTOR_BITS-1:0] i_head,
    input  logic [SECTOR_BITS-1:0] i_sector,
    input  logic [SECTOR_BITS-1:0] i_best_dist,
    input  logic [TAG_BITS-1:0]    i_slot_tag,
    input  logic [TAG_BITS-1:0]    i_req_tag,
    output t_cmp_res               o_res
);

    logic                   above;
    logic [SECTOR_BITS-1:0] distance;

    // absolute distance from the head
    assign above    = i_sector > i_head;
    assign distance = above ? (i_sector - i_head) : (i_head - i_sector);

    // strictly closer than the best so far, direction, tag match
    always_comb begin
        o_res.distance = distance;
        o_res.closer   = distance < i_best_dist;
        o_res.right    = above;
        o_res.tag_hit  = i_slot_tag == i_req_tag;
    end

endmodule

>>> rtl/sstf_request_scheduler.sv
`timescale 1ns / 1ps
// every operation but the unused code scans all QUEUE_DEPTH slots, one slot per cycle
// through the slot RAM's registered read port and the shared compare unit
// the result is registered in S_DONE after the scan; the unused code skips the scan
// one item at a time: the next input transfer waits until S_DONE has loaded the result
// register, and S_DONE waits while a waiting result still holds the output register
// synchronous active-low reset empties the queue (valid bits) and sets the head to 0;
// slot RAM contents are not cleared

module sstf_request_scheduler
    import sstf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [FIELD_BITS-1:0] i_request_sector,
    input  logic [TAG_BITS-1:0]   i_request_tag,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [TAG_BITS-1:0]   o_chosen_tag,
    output logic [FIELD_BITS-1:0] o_chosen_sector,
    output logic                  o_seek_right
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic                   r_pend_v, n_pend_v;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_best_idx, n_best_idx;
    logic [SECTOR_BITS-1:0] r_best_dist, n_best_dist;
    logic [SECTOR_BITS-1:0] r_best_sector, n_best_sector;
    logic [TAG_BITS-1:0]    r_best_tag, n_best_tag;
    logic                   r_best_right, n_best_right;
    t_op                    r_op, n_op;
    logic [SECTOR_BITS-1:0] r_req_sector, n_req_sector;
    logic [TAG_BITS-1:0]    r_req_tag, n_req_tag;
    logic [SECTOR_BITS-1:0] r_head, n_head;
    logic [QUEUE_DEPTH-1:0] r_slot_valid, n_slot_valid;
    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic [TAG_BITS-1:0]    r_out_tag, n_out_tag;
    logic [FIELD_BITS-1:0]  r_out_sector, n_out_sector;
    logic                   r_out_right, n_out_right;

    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [SLOT_W-1:0]      ram_wr_data;
    logic [SLOT_W-1:0]      ram_rd_data;
    logic [SECTOR_BITS-1:0] rd_sector;
    logic [TAG_BITS-1:0]    rd_tag;
    t_cmp_res               cmp;

    // slot store: {tag, sector}
    sstf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_best_idx),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_sector   = ram_rd_data[SECTOR_BITS-1:0];
    assign rd_tag      = ram_rd_data[SECTOR_BITS +: TAG_BITS];
    assign ram_wr_data = {r_req_tag, r_req_sector};
    assign ram_rd_addr = r_cnt[IDX_W-1:0];

    // shared distance / tag compare unit
    sstf_cmp_unit u_cmp (
        .i_head      (r_head),
        .i_sector    (rd_sector),
        .i_best_dist (r_best_dist),
        .i_slot_tag  (rd_tag),
        .i_req_tag   (r_req_tag),
        .o_res       (cmp)
    );

    // sequencer next state
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_pend_v      = r_pend_v;
        n_found       = r_found;
        n_best_idx    = r_best_idx;
        n_best_dist   = r_best_dist;
        n_best_sector = r_best_sector;
        n_best_tag    = r_best_tag;
        n_best_right  = r_best_right;
        n_op          = r_op;
        n_req_sector  = r_req_sector;
        n_req_tag     = r_req_tag;
        n_head        = r_head;
        n_slot_valid  = r_slot_valid;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_out_tag     = r_out_tag;
        n_out_sector  = r_out_sector;
        n_out_right   = r_out_right;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;

        // output transfer frees the result register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = t_op'(i_operation);
                    n_req_sector = to_sector(i_request_sector);
                    n_req_tag    = i_request_tag;
                    n_cnt        = '0;
                    n_pend       = 1'b0;
                    n_found      = 1'b0;
                    n_best_dist  = '0;
                    n_state      = (t_op'(i_operation) == OP_NONE) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // evaluate the slot read in the previous cycle
                if (r_pend) begin
                    case (r_op)
                        OP_ADD: begin
                            if (!r_pend_v && !r_found) begin
                                n_found    = 1'b1;
                                n_best_idx = r_pend_idx;
                            end
                        end
                        OP_DISPATCH: begin
                            if (r_pend_v && (!r_found || cmp.closer)) begin
                                n_found       = 1'b1;
                                n_best_idx    = r_pend_idx;
                                n_best_dist   = cmp.distance;
                                n_best_sector = rd_sector;
                                n_best_tag    = rd_tag;
                                n_best_right  = cmp.right;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_pend_v && cmp.tag_hit && !r_found) begin
                                n_found    = 1'b1;
                                n_best_idx = r_pend_idx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // issue the next slot read, or drain
                if (r_cnt < DEPTH_CNT) begin
                    ram_rd_en  = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_cnt[IDX_W-1:0];
                    n_pend_v   = r_slot_valid[r_cnt[IDX_W-1:0]];
                    n_cnt      = r_cnt + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_status     = ST_OK;
                    n_out_tag    = '0;
                    n_out_sector = '0;
                    n_out_right  = 1'b0;
                    case (r_op)
                        OP_ADD: begin
                            if (r_found) begin
                                ram_wr_en                = 1'b1;
                                n_slot_valid[r_best_idx] = 1'b1;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_DISPATCH: begin
                            if (r_found) begin
                                n_slot_valid[r_best_idx] = 1'b0;
                                n_head       = r_best_sector;
                                n_out_tag    = r_best_tag;
                                n_out_sector = to_field(r_best_sector);
                                n_out_right  = r_best_right;
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found) begin
                                n_slot_valid[r_best_idx] = 1'b0;
                            end else begin
                                n_status = ST_NOTAG;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_head       <= '0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend       <= n_pend;
            r_found      <= n_found;
            r_head       <= n_head;
            r_slot_valid <= n_slot_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pend_idx    <= n_pend_idx;
        r_pend_v      <= n_pend_v;
        r_best_idx    <= n_best_idx;
        r_best_dist   <= n_best_dist;
        r_best_sector <= n_best_sector;
        r_best_tag    <= n_best_tag;
        r_best_right  <= n_best_right;
        r_op          <= n_op;
        r_req_sector  <= n_req_sector;
        r_req_tag     <= n_req_tag;
        r_status      <= n_status;
        r_out_tag     <= n_out_tag;
        r_out_sector  <= n_out_sector;
        r_out_right   <= n_out_right;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_chosen_tag    = r_out_tag;
    assign o_chosen_sector = r_out_sector;
    assign o_seek_right    = r_out_right;

endmodule
